// ===== hw/rtl/bounded_stack_engine_top_macros.svh =====
// assertion helpers shared by the stack engine front and back
`ifndef BOUNDED_STACK_ENGINE_TOP_MACROS_SVH
`define BOUNDED_STACK_ENGINE_TOP_MACROS_SVH

// check that holds only once reset is released
`define BSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that holds on every edge, reset included
`define BSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/bse_pkg.sv =====
`timescale 1ns / 1ps

package bse_pkg;

  // command codes of an input item
  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_MODIFY = 3'd3,
    CMD_DUMP   = 3'd4
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_ABSENT    = 2'd3
  } status_e;

  // work kinds handed from front to back
  typedef enum logic [1:0] {
    OP_ACK   = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_DUMP  = 2'd3
  } op_kind_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
    logic [2:0]         depth_from_top;
  } bse_in_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic               last;
  } bse_out_t;

endpackage

// ===== hw/rtl/bse_front.sv =====
`timescale 1ns / 1ps
`include "bounded_stack_engine_top_macros.svh"

module bse_front import bse_pkg::*; #(
  parameter int unsigned DEPTH = 8,
  parameter type op_t = logic
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  bse_in_t in_item_i,
  output logic    enq_valid_o,
  input  logic    enq_stall_i,
  output op_t     enq_op_o
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned CmpW  = (CntW > 3) ? CntW : 3;

  logic [CntW-1:0] fill_q, fill_d;
  logic            accept;
  logic            known;
  logic            full, empty;
  logic [CmpW-1:0] fill_ext, depth_ext, mod_idx;
  logic [AddrW-1:0] top_addr;
  op_t             op;

  assign accept    = in_valid_i && !enq_stall_i;
  assign full      = (fill_q == CntW'(DEPTH));
  assign empty     = (fill_q == '0);
  assign fill_ext  = CmpW'(fill_q);
  assign depth_ext = CmpW'(in_item_i.depth_from_top);
  assign mod_idx   = fill_ext - CmpW'(1) - depth_ext;
  assign top_addr  = AddrW'(fill_q - CntW'(1));

  // classify the item against the current fill level
  always_comb begin
    op     = '0;
    known  = 1'b1;
    fill_d = fill_q;
    case (cmd_e'(in_item_i.command))
      CMD_PUSH: begin
        if (full) begin
          op.kind   = OP_ACK;
          op.status = ST_OVERFLOW;
        end else begin
          op.kind   = OP_WRITE;
          op.status = ST_OK;
          op.addr   = AddrW'(fill_q);
          op.value  = in_item_i.value;
          fill_d    = fill_q + CntW'(1);
        end
      end
      CMD_POP: begin
        if (empty) begin
          op.kind   = OP_ACK;
          op.status = ST_UNDERFLOW;
        end else begin
          op.kind   = OP_READ;
          op.status = ST_OK;
          op.addr   = top_addr;
          fill_d    = fill_q - CntW'(1);
        end
      end
      CMD_PEEK: begin
        if (empty) begin
          op.kind   = OP_ACK;
          op.status = ST_UNDERFLOW;
        end else begin
          op.kind   = OP_READ;
          op.status = ST_OK;
          op.addr   = top_addr;
        end
      end
      CMD_MODIFY: begin
        if (depth_ext >= fill_ext) begin
          op.kind   = OP_ACK;
          op.status = ST_ABSENT;
        end else begin
          op.kind   = OP_WRITE;
          op.status = ST_OK;
          op.addr   = AddrW'(mod_idx);
          op.value  = in_item_i.value;
        end
      end
      CMD_DUMP: begin
        // addr carries the index of the top entry, the last one dumped
        if (empty) begin
          op.kind   = OP_ACK;
          op.status = ST_UNDERFLOW;
        end else begin
          op.kind   = OP_DUMP;
          op.status = ST_OK;
          op.addr   = top_addr;
        end
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // fill level tracks every accepted item in order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (accept) begin
      fill_q <= fill_d;
    end
  end

  assign in_stall_o  = enq_stall_i;
  assign enq_valid_o = in_valid_i && known;
  assign enq_op_o    = op;

  `BSE_ASSERT(a_fill_bound, fill_q <= CntW'(DEPTH), "fill level beyond capacity")
  `BSE_ASSERT(a_fill_step, !accept |=> fill_q == $past(fill_q), "fill moved without an item")
  `BSE_ASSERT(a_unknown_drop, accept && (in_item_i.command > CMD_DUMP) |-> !enq_valid_o,
              "unused command reached the queue")

endmodule

// ===== hw/rtl/bse_queue.sv =====
`timescale 1ns / 1ps

module bse_queue import bse_pkg::*; #(
  parameter type op_t = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic enq_valid_i,
  output logic enq_stall_o,
  input  op_t  enq_op_i,
  output logic deq_valid_o,
  input  logic deq_pop_i,
  output op_t  deq_op_o
);

  logic [1:0] cnt_q;
  logic       wr_ptr_q, rd_ptr_q;
  logic       push, pop;
  op_t        slot_q [2];

  assign enq_stall_o = (cnt_q == 2'd2);
  assign deq_valid_o = (cnt_q != 2'd0);
  assign push        = enq_valid_i && !enq_stall_o;
  assign pop         = deq_pop_i && deq_valid_o;
  assign deq_op_o    = slot_q[rd_ptr_q];

  // two-slot ring, pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= enq_op_i;
    end
  end

endmodule

// ===== hw/rtl/bse_back.sv =====
`timescale 1ns / 1ps
`include "bounded_stack_engine_top_macros.svh"

module bse_back import bse_pkg::*; #(
  parameter int unsigned DEPTH = 8,
  parameter type op_t = logic
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     head_valid_i,
  output logic     head_pop_o,
  input  op_t      head_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bse_out_t out_item_o
);

  localparam int unsigned AddrW = $clog2(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e           state_q;
  logic             out_valid_q;
  bse_out_t         out_q;
  logic [AddrW-1:0] idx_q, last_idx_q;
  logic             out_free;
  logic             pop;
  logic             wr_en, rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [31:0]      mem_q [DEPTH];
  logic [31:0]      rd_data_q;

  assign out_free = !out_valid_q || !out_stall_i;

  // memory port control
  always_comb begin
    pop     = 1'b0;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_q)
      S_IDLE: begin
        if (head_valid_i && out_free) begin
          pop = 1'b1;
          case (head_i.kind)
            OP_WRITE: wr_en = 1'b1;
            OP_READ: begin
              rd_en   = 1'b1;
              rd_addr = head_i.addr;
            end
            OP_DUMP: begin
              rd_en   = 1'b1;
              rd_addr = '0;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        // fetch the next dump entry while the current one goes out
        if (out_free && (idx_q != last_idx_q)) begin
          rd_en   = 1'b1;
          rd_addr = idx_q + AddrW'(1);
        end
      end
      default: ;
    endcase
  end

  // stack storage, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[head_i.addr] <= head_i.value;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      idx_q       <= '0;
      last_idx_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (pop) begin
            case (head_i.kind)
              OP_READ, OP_DUMP: begin
                out_valid_q <= 1'b0;
                idx_q       <= '0;
                last_idx_q  <= (head_i.kind == OP_DUMP) ? head_i.addr : '0;
                state_q     <= S_READ;
              end
              default: begin
                out_valid_q <= 1'b1;
                out_q.data   <= '0;
                out_q.status <= head_i.status;
                out_q.last   <= 1'b1;
              end
            endcase
          end else if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
        end
        S_READ: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_q.data   <= rd_data_q;
            out_q.status <= ST_OK;
            out_q.last   <= (idx_q == last_idx_q);
            if (idx_q == last_idx_q) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q + AddrW'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign head_pop_o  = pop;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `BSE_ASSERT(a_no_pop_busy, state_q == S_READ |-> !pop, "queue popped during a read")
  `BSE_ASSERT(a_one_port, !(wr_en && rd_en), "memory written and read together")
  `BSE_ASSERT(a_read_end, state_q == S_READ && out_free && idx_q == last_idx_q |=>
              state_q == S_IDLE && out_valid_q && out_q.last, "read run ended without last")

endmodule

// ===== hw/rtl/bounded_stack_engine_top.sv =====
`timescale 1ns / 1ps

// Bounded LIFO stack of DEPTH signed 32-bit words with push, pop, peek, modify at a
// depth below the top, and dump from bottom to top. The front decodes each item
// against its own fill level and hands the work through a two-slot queue to the back,
// which owns the single-port word memory and the result register. The front takes
// one item per cycle while the queue has room; unused command codes are taken and
// give no result. In the back, push, modify and every error case go straight to the
// result register; pop, peek and dump first read the one memory port, a dump going
// bottom to top, and take no new item until done. No clearing pass follows reset.
module bounded_stack_engine_top import bse_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  bse_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bse_out_t out_item_o
);

  localparam int unsigned AddrW = $clog2(DEPTH);

  typedef struct packed {
    op_kind_e           kind;
    status_e            status;
    logic [AddrW-1:0]   addr;
    logic signed [31:0] value;
  } op_t;

  logic enq_valid, enq_stall;
  op_t  enq_op;
  logic head_valid, head_pop;
  op_t  head_op;

  bse_front #(
    .DEPTH (DEPTH),
    .op_t  (op_t)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .enq_valid_o (enq_valid),
    .enq_stall_i (enq_stall),
    .enq_op_o    (enq_op)
  );

  bse_queue #(
    .op_t (op_t)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enq_valid_i (enq_valid),
    .enq_stall_o (enq_stall),
    .enq_op_i    (enq_op),
    .deq_valid_o (head_valid),
    .deq_pop_i   (head_pop),
    .deq_op_o    (head_op)
  );

  bse_back #(
    .DEPTH (DEPTH),
    .op_t  (op_t)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .head_i       (head_op),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule
